FILE: rtl/ttg_pkg.sv
// ----------------------------------------------------------------------------
// ttg_pkg
// Shared types and constants for the triangle tone generator.
// ----------------------------------------------------------------------------
package ttg_pkg;

    localparam int PHASE_W = 18;                 // phase, rate and step width
    localparam int AMP_W   = 15;                 // peak level width
    localparam int OUT_W   = 16;                 // sample width
    localparam int QTR_W   = PHASE_W - 2;        // rate / 4
    localparam int NUM_W   = AMP_W + PHASE_W;    // peak * offset
    localparam int QUOT_W  = 17;                 // quotient never reaches 3 * peak + 1
    localparam int SUM_W   = QUOT_W + 2;         // signed sample before clamp
    localparam int CNT_W   = $clog2(NUM_W);
    localparam int CFG_A_W = 2;

    localparam logic [PHASE_W-1:0] RATE_RST = PHASE_W'(48000);
    localparam logic [PHASE_W-1:0] STEP_RST = PHASE_W'(440);
    localparam logic [AMP_W-1:0]   PEAK_RST = AMP_W'(6000);

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32767);

    typedef enum logic [CFG_A_W-1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_TONE_STEP   = 2'd1,
        REG_PEAK_LEVEL  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } ttg_state_t;

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_FALL,
        SEG_RETURN
    } seg_t;

    typedef struct packed {
        logic                start;
        logic [NUM_W-1:0]    num;
        logic [QTR_W-1:0]    den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [QUOT_W-1:0]   quot;
    } div_rsp_t;

endpackage

FILE: rtl/ttg_div.sv
// ----------------------------------------------------------------------------
// ttg_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttg_div import ttg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [QTR_W-1:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [QTR_W-1:0]   den_reg, den_next;

    logic [QTR_W:0]     shifted;
    logic [QTR_W:0]     diff;
    logic               ge;

    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = req.num;
            den_next  = req.den;
        end else if (busy_reg) begin
            rem_next = ge ? diff[QTR_W-1:0] : shifted[QTR_W-1:0];
            num_next = {num_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg[QUOT_W-1:0];

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start)
        else $error("divider restarted while busy");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");
`endif

endmodule

FILE: rtl/triangle_tone_generator.sv
// Sequence: an accepted input transaction runs through SETUP, MUL, DIV_START, DIV_WAIT
// and DONE to m_valid; DIV_START and DIV_WAIT are skipped when the sample is forced to zero
// (phase at or above the rate, or quarter of zero). The serial divider yields one quotient
// bit per cycle, and s_ready is high only while idle, so a new input waits for DONE.
// A finished sample waits in the output register while the next frame runs.
// Reset (aresetn, synchronous, active low): phase cleared, rate 48000, step 440,
// peak 6000, output empty.
// ----------------------------------------------------------------------------
// triangle_tone_generator
// DDS triangle wave: phase accumulator plus a sequencer around a single divider.
// ----------------------------------------------------------------------------
module triangle_tone_generator import ttg_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_A_W-1:0]      cfg_addr,
    input  logic [PHASE_W-1:0]      cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_restart,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_tone_out
);

    ttg_state_t state_reg, state_next;

    logic [PHASE_W-1:0] rate_reg, step_reg;
    logic [AMP_W-1:0]   peak_reg;
    logic [PHASE_W-1:0] phase_acc_reg;
    logic [PHASE_W-1:0] ph_reg;
    logic [PHASE_W-1:0] d_reg;
    seg_t               seg_reg;
    logic               zero_reg;
    logic [NUM_W-1:0]   prod_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic               m_valid_reg;
    logic signed [OUT_W-1:0] tone_reg;

    logic               accept;
    logic               load_out;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [QTR_W-1:0]   quarter;
    logic [PHASE_W-1:0] q_ext, q3;
    logic [PHASE_W:0]   sum, wrapped;
    logic signed [SUM_W-1:0] quot_s, peak_s, samp, samp_sat;

    assign accept  = s_valid && s_ready;
    assign quarter = rate_reg[PHASE_W-1:2];
    assign q_ext   = {2'b00, quarter};
    assign q3      = PHASE_W'({1'b0, quarter, 1'b0}) + q_ext;

    // phase advance: one conditional wrap, then truncate to the phase width
    assign sum     = {1'b0, ph_reg} + {1'b0, step_reg};
    assign wrapped = (sum >= {1'b0, rate_reg}) ? sum - {1'b0, rate_reg} : sum;

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        load_out    = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = prod_reg;
        div_req.den   = quarter;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = zero_reg ? ST_DONE : ST_DIV_START;
            end
            ST_DIV_START: begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    ttg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rate_reg      <= RATE_RST;
            step_reg      <= STEP_RST;
            peak_reg      <= PEAK_RST;
            phase_acc_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_SAMPLE_RATE: rate_reg <= cfg_wdata;
                    REG_TONE_STEP:   step_reg <= cfg_wdata;
                    REG_PEAK_LEVEL:  peak_reg <= cfg_wdata[AMP_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_SETUP) begin
                phase_acc_reg <= wrapped[PHASE_W-1:0];
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            ph_reg <= s_restart ? '0 : phase_acc_reg;
        end
        if (state_reg == ST_SETUP) begin
            zero_reg <= (ph_reg >= rate_reg) || (quarter == '0);
            if (ph_reg < q_ext) begin
                seg_reg <= SEG_RISE;
                d_reg   <= ph_reg;
            end else if (ph_reg < q3) begin
                seg_reg <= SEG_FALL;
                d_reg   <= ph_reg - q_ext;
            end else begin
                seg_reg <= SEG_RETURN;
                d_reg   <= ph_reg - q3;
            end
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= NUM_W'(peak_reg) * NUM_W'(d_reg);
        end
        if (div_rsp.done) begin
            quot_reg <= div_rsp.quot;
        end
        if (load_out) begin
            tone_reg <= samp_sat[OUT_W-1:0];
        end
    end

    assign quot_s = {2'b00, quot_reg};
    assign peak_s = {{(SUM_W-AMP_W){1'b0}}, peak_reg};

    always_comb begin
        case (seg_reg)
            SEG_RISE:   samp = quot_s;
            SEG_FALL:   samp = peak_s - quot_s;
            SEG_RETURN: samp = quot_s - peak_s;
            default:    samp = '0;
        endcase
        if (zero_reg) begin
            samp_sat = '0;
        end else if (samp > SAT_HI) begin
            samp_sat = SAT_HI;
        end else if (samp < SAT_LO) begin
            samp_sat = SAT_LO;
        end else begin
            samp_sat = samp;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_tone_out = tone_reg;

`ifndef SYNTH
    a_accept_to_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_SETUP)
        else $error("accepted transaction did not start setup");
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid_reg)
        else $error("finished sample not presented");
    a_div_done_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside the wait state");
    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_tone_out != 16'sh8000)
        else $error("sample outside saturation range");
`endif

endmodule
